### rtl/core/dpm_pkg.sv
// Shared types, operation codes and constants for the program mixer.
// No dependencies; the mixer top level imports this package.
package dpm_pkg;

  localparam int DEF_CHANNELS      = 512;
  localparam int DEF_PROGRAM_STEPS = 64;
  localparam int MAX_STEPS         = 64;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 10;

  localparam logic [CFG_INDEX_W-1:0] CFG_STEP_COUNT    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_PROGRAM_WIDTH = 2'd1;

  localparam logic [3:0] OP_OVERRIDE = 4'd0;
  localparam logic [3:0] OP_MASTER   = 4'd1;
  localparam logic [3:0] OP_BLACKOUT = 4'd2;
  localparam logic [3:0] OP_CHASE    = 4'd3;
  localparam logic [3:0] OP_BPM      = 4'd4;
  localparam logic [3:0] OP_RUN      = 4'd5;
  localparam logic [3:0] OP_RESTART  = 4'd6;
  localparam logic [3:0] OP_TICK     = 4'd7;
  localparam logic [3:0] OP_LOAD     = 4'd8;
  localparam logic [3:0] OP_RENDER   = 4'd9;

  localparam logic [7:0]  FULL_LEVEL       = 8'd255;
  localparam logic [7:0]  BUTTON_THRESHOLD = 8'd64;
  localparam logic [7:0]  BPM_LOW          = 8'd30;
  localparam logic [7:0]  BPM_SPAN         = 8'd150;
  localparam logic [25:0] US_PER_MINUTE    = 26'd60000000;
  localparam logic [20:0] RESET_WAIT       = 21'd1000000;
  localparam logic [20:0] WAIT_MIN         = 21'd333333;
  localparam logic [20:0] WAIT_MAX         = 21'd2000000;

  typedef struct packed {
    logic [3:0] operation;
    logic [8:0] channel;
    logic [7:0] value;
    logic [5:0] step_index;
  } item_t;

  typedef struct packed {
    logic [8:0] out_channel;
    logic [7:0] level;
    logic [5:0] current_step;
    logic       running;
    logic       blackout;
  } result_t;

  // x / 255 for any product of two bytes
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] s;
    begin
      s = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
      return s[15:8];
    end
  endfunction

endpackage

### rtl/core/dmx_program_mixer.sv
// Program mixer top level: state, program and override stores, serial datapath.
// Depends on dpm_pkg for beat types, operation codes and constants.
//
// Usage:
//   item channel (item_valid/item_ready/item) carries one operation per beat.
//   Override, fader, button, tick, restart and load beats take effect at the
//   accepting edge and produce nothing; the block is ready again next cycle.
//   A render beat yields one result beat on result_valid/result_ready.
//   A render reads both stores at the accepting edge, then scales the program
//   byte by chase and master with a bit-serial shift-add multiplier, one after
//   the other, and loads the result register; a manual channel or one outside
//   the program skips the multiplier. A BPM beat runs the multiplier and a
//   restoring divider, one quotient bit a cycle, then updates the step wait.
//   One item is worked on at a time; the result register lets the next item
//   be taken while a finished result waits. If the receiver stalls, a second
//   render holds in its output state until the waiting result is taken.
//   cfg channel is always ready: index 0 step count, index 1 program width.
//   Reset (rst, synchronous) sets faders full, clears timer and step at once,
//   then a pass over every override address clears override levels and manual
//   flags with item_ready low; the program store stays undefined until loaded.
module dmx_program_mixer
  import dpm_pkg::*;
#(
  parameter int CHANNELS      = DEF_CHANNELS,
  parameter int PROGRAM_STEPS = DEF_PROGRAM_STEPS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  output logic                   item_ready,
  input  item_t                  item,
  output logic                   result_valid,
  input  logic                   result_ready,
  output result_t                result,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int STEP_SLOTS = (PROGRAM_STEPS < MAX_STEPS) ? PROGRAM_STEPS : MAX_STEPS;
  localparam int CH_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SLOT_W     = (STEP_SLOTS > 1) ? $clog2(STEP_SLOTS) : 1;
  localparam int PROG_DEPTH = 2 ** (SLOT_W + CH_W);
  localparam int OVR_DEPTH  = 2 ** CH_W;
  localparam logic [6:0] STEP_LIMIT = 7'(STEP_SLOTS);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_DIFF  = 3'd4;
  localparam logic [2:0] S_PULL  = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;
  localparam logic [2:0] S_CLEAR = 3'd7;

  localparam logic [1:0] M_CHASE  = 2'd0;
  localparam logic [1:0] M_MASTER = 2'd1;
  localparam logic [1:0] M_BPM    = 2'd2;

  logic [2:0]  state;
  logic [1:0]  mode;
  logic [4:0]  cnt;
  logic [CH_W-1:0] clr_addr;

  logic [6:0]  step_count;
  logic [9:0]  program_width;
  logic [7:0]  master;
  logic [7:0]  saved_master;
  logic        blackout;
  logic [7:0]  chase;
  logic        running;
  logic [5:0]  step_counter;
  logic [20:0] wait_us;
  logic [22:0] countdown;

  logic [7:0] program_mem [PROG_DEPTH];
  logic [8:0] override_mem [OVR_DEPTH];
  logic [7:0] prog_q;
  logic [8:0] ovr_q;

  logic [8:0]  r_channel;
  logic        r_ch_ok;
  logic        r_zero;
  logic [7:0]  level;

  logic [15:0] mul_a;
  logic [7:0]  mul_b;
  logic [15:0] mul_acc;
  logic [15:0] mul_acc_next;
  logic [7:0]  mul_out;

  logic [7:0]  div_d;
  logic [7:0]  div_rem;
  logic [25:0] div_q;
  logic [8:0]  div_r;
  logic        div_ge;

  logic        pull;
  logic [20:0] diff;

  logic        accept;
  logic        ch_ok;
  logic        step_ok;
  logic        below_width;
  logic [CH_W-1:0] ch_idx;
  logic [6:0]  step_plus;
  logic [6:0]  eff_steps;

  function automatic logic [6:0] eff_of(input logic [6:0] n);
    begin
      if (n == 7'd0) return 7'd1;
      else if (n > STEP_LIMIT) return STEP_LIMIT;
      else return n;
    end
  endfunction

  assign item_ready  = (state == S_IDLE);
  assign cfg_ready   = 1'b1;
  assign accept      = item_valid && item_ready;
  assign ch_idx      = item.channel[CH_W-1:0];
  assign ch_ok       = 32'(item.channel) < CHANNELS;
  assign step_ok     = 32'(item.step_index) < PROGRAM_STEPS;
  assign below_width = 32'(item.channel) < 32'(program_width);
  assign eff_steps   = eff_of(step_count);
  assign step_plus   = {1'b0, step_counter} + 7'd1;

  assign mul_acc_next = mul_acc + (mul_b[0] ? mul_a : 16'd0);
  assign mul_out      = div255(mul_acc_next);

  assign div_r  = {div_rem, div_q[25]};
  assign div_ge = div_r >= {1'b0, div_d};

  always_ff @(posedge clk) begin
    if (accept && item.operation == OP_LOAD && ch_ok && step_ok) begin
      program_mem[{item.step_index[SLOT_W-1:0], ch_idx}] <= item.value;
    end
    if (accept) begin
      prog_q <= program_mem[{step_counter[SLOT_W-1:0], ch_idx}];
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_CLEAR) begin
      override_mem[clr_addr] <= '0;
    end else if (accept && item.operation == OP_OVERRIDE && ch_ok) begin
      override_mem[ch_idx] <= {1'b1, item.value};
    end
    if (accept) begin
      ovr_q <= override_mem[ch_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_addr     <= '0;
      mode         <= M_CHASE;
      cnt          <= '0;
      step_count   <= 7'd1;
      program_width <= '0;
      master       <= FULL_LEVEL;
      saved_master <= '0;
      blackout     <= 1'b0;
      chase        <= FULL_LEVEL;
      running      <= 1'b1;
      step_counter <= '0;
      wait_us      <= RESET_WAIT;
      countdown    <= '0;
      result_valid <= 1'b0;
    end else begin
      if (state == S_OUT && (!result_valid || result_ready)) begin
        result_valid <= 1'b1;
      end else if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (&clr_addr) state <= S_IDLE;
        end
        S_IDLE: begin
          if (accept) begin
            case (item.operation)
              OP_MASTER: begin
                if (blackout) saved_master <= item.value;
                else master <= item.value;
              end
              OP_BLACKOUT: begin
                if (item.value >= BUTTON_THRESHOLD) begin
                  if (!blackout) begin
                    saved_master <= master;
                    master       <= '0;
                    blackout     <= 1'b1;
                  end else begin
                    master   <= saved_master;
                    blackout <= 1'b0;
                  end
                end
              end
              OP_CHASE: chase <= item.value;
              OP_BPM: begin
                mul_a   <= {8'd0, BPM_SPAN};
                mul_b   <= item.value;
                mul_acc <= '0;
                cnt     <= '0;
                mode    <= M_BPM;
                state   <= S_MUL;
              end
              OP_RUN: begin
                if (item.value >= BUTTON_THRESHOLD) begin
                  running <= ~running;
                  if (!running) countdown <= '0;
                end
              end
              OP_RESTART: countdown <= '0;
              OP_TICK: begin
                if (countdown > 23'd1) begin
                  countdown <= countdown - 23'd1;
                end else begin
                  countdown <= countdown + {2'b0, wait_us} - 23'd1;
                  if (running) begin
                    step_counter <= (step_plus >= eff_steps) ? 6'd0 : step_plus[5:0];
                  end
                end
              end
              OP_RENDER: begin
                r_channel <= item.channel;
                r_ch_ok   <= ch_ok;
                r_zero    <= !ch_ok || !below_width;
                state     <= S_READ;
              end
              default: begin
              end
            endcase
          end
        end
        S_READ: begin
          if (r_ch_ok && ovr_q[8]) begin
            level <= ovr_q[7:0];
            state <= S_OUT;
          end else if (r_zero) begin
            level <= '0;
            state <= S_OUT;
          end else begin
            mul_a   <= {8'd0, prog_q};
            mul_b   <= chase;
            mul_acc <= '0;
            cnt     <= '0;
            mode    <= M_CHASE;
            state   <= S_MUL;
          end
        end
        S_MUL: begin
          if (cnt == 5'd7) begin
            cnt <= '0;
            case (mode)
              M_CHASE: begin
                mul_a   <= {8'd0, mul_out};
                mul_b   <= master;
                mul_acc <= '0;
                mode    <= M_MASTER;
              end
              M_MASTER: begin
                level <= mul_out;
                state <= S_OUT;
              end
              M_BPM: begin
                div_d   <= BPM_LOW + mul_out;
                div_rem <= '0;
                div_q   <= US_PER_MINUTE;
                state   <= S_DIV;
              end
              default: state <= S_IDLE;
            endcase
          end else begin
            mul_acc <= mul_acc_next;
            mul_a   <= {mul_a[14:0], 1'b0};
            mul_b   <= {1'b0, mul_b[7:1]};
            cnt     <= cnt + 5'd1;
          end
        end
        S_DIV: begin
          div_rem <= div_ge ? 8'(div_r - {1'b0, div_d}) : div_r[7:0];
          div_q   <= {div_q[24:0], div_ge};
          cnt     <= cnt + 5'd1;
          if (cnt == 5'd25) state <= S_DIFF;
        end
        S_DIFF: begin
          pull    <= wait_us > div_q[20:0];
          diff    <= wait_us - div_q[20:0];
          wait_us <= div_q[20:0];
          state   <= S_PULL;
        end
        S_PULL: begin
          if (pull) begin
            countdown <= (countdown > {2'b0, diff}) ? countdown - {2'b0, diff} : '0;
          end
          state <= S_IDLE;
        end
        S_OUT: begin
          if (!result_valid || result_ready) begin
            result.out_channel  <= r_channel;
            result.level        <= level;
            result.current_step <= step_counter;
            result.running      <= running;
            result.blackout     <= blackout;
            state               <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_STEP_COUNT: begin
            step_count <= cfg_data[6:0];
            if ({1'b0, step_counter} >= eff_of(cfg_data[6:0])) step_counter <= '0;
          end
          CFG_PROGRAM_WIDTH: program_width <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_step_in_range: assert property (@(posedge clk) disable iff (rst)
    {1'b0, step_counter} < eff_steps)
    else $error("step counter beyond step count");

  a_blackout_dark: assert property (@(posedge clk) disable iff (rst)
    blackout |-> master == 8'd0)
    else $error("master live during blackout");

  a_wait_range: assert property (@(posedge clk) disable iff (rst)
    wait_us >= WAIT_MIN && wait_us <= WAIT_MAX)
    else $error("step wait out of range");

  a_render_starts: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready && item.operation == OP_RENDER |=> state == S_READ)
    else $error("render beat not started");
`endif

endmodule

### verif/mixer_checker.sv
`timescale 1ns / 1ps
// Checker for the program mixer: watches the item, result and register channels,
// predicts every render beat and compares it field by field. Depends on dpm_pkg.
module mixer_checker
  import dpm_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  input  logic                   item_ready,
  input  item_t                  item,
  input  logic                   result_valid,
  input  logic                   result_ready,
  input  result_t                result,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     fault_count,
  output int                     awaiting,
  output logic [5:0]             step_now
);

  logic [7:0]  prog_mem [MAX_STEPS*DEF_CHANNELS];
  logic [7:0]  ovr_lvl [DEF_CHANNELS];
  logic        manual [DEF_CHANNELS];
  logic [7:0]  master;
  logic [7:0]  saved;
  logic [7:0]  chase;
  logic        blk;
  logic        run;
  logic [5:0]  step;
  logic [20:0] wait_us;
  logic [22:0] countdown;
  logic [6:0]  step_count;
  logic [9:0]  prog_width;
  result_t     levels_due [$];
  int          mismatches = 0;

  function automatic logic [7:0] fade(input logic [7:0] a, input logic [7:0] b);
    int prod;
    prod = int'(a) * int'(b);
    return 8'(prod / int'(FULL_LEVEL));
  endfunction

  function automatic int steps_in_use();
    int n;
    int cap;
    cap = (DEF_PROGRAM_STEPS < MAX_STEPS) ? DEF_PROGRAM_STEPS : MAX_STEPS;
    n = int'(step_count);
    if (n == 0) n = 1;
    if (n > cap) n = cap;
    return n;
  endfunction

  function automatic result_t mixed_level(input logic [8:0] ch);
    result_t    r;
    int         span;
    logic [7:0] lvl;
    span = (int'(prog_width) > DEF_CHANNELS) ? DEF_CHANNELS : int'(prog_width);
    if (manual[ch] || int'(ch) >= span) lvl = ovr_lvl[ch];
    else lvl = fade(prog_mem[{step, ch}], chase);
    if (!manual[ch]) lvl = fade(lvl, master);
    r.out_channel  = ch;
    r.level        = lvl;
    r.current_step = step;
    r.running      = run;
    r.blackout     = blk;
    return r;
  endfunction

  function automatic void apply_beat(input item_t it);
    int bpm;
    int nw;
    int pull;
    case (it.operation)
      OP_OVERRIDE: begin
        manual[it.channel]  = 1'b1;
        ovr_lvl[it.channel] = it.value;
      end
      OP_MASTER: begin
        if (blk) saved = it.value;
        else master = it.value;
      end
      OP_BLACKOUT: begin
        if (it.value >= BUTTON_THRESHOLD) begin
          if (!blk) begin
            saved  = master;
            master = '0;
            blk    = 1'b1;
          end else begin
            master = saved;
            blk    = 1'b0;
          end
        end
      end
      OP_CHASE: chase = it.value;
      OP_BPM: begin
        bpm = int'(BPM_LOW) + int'(BPM_SPAN) * int'(it.value) / int'(FULL_LEVEL);
        nw  = int'(US_PER_MINUTE) / bpm;
        if (int'(wait_us) > nw) begin
          pull = int'(wait_us) - nw;
          countdown = (int'(countdown) > pull) ? 23'(int'(countdown) - pull) : '0;
        end
        wait_us = 21'(nw);
      end
      OP_RUN: begin
        if (it.value >= BUTTON_THRESHOLD) begin
          run = ~run;
          if (run) countdown = '0;
        end
      end
      OP_RESTART: countdown = '0;
      OP_TICK: begin
        if (countdown > 23'd1) begin
          countdown = countdown - 23'd1;
        end else begin
          countdown = 23'(int'(countdown) + int'(wait_us) - 1);
          if (run) step = (int'(step) + 1 >= steps_in_use()) ? 6'd0 : step + 6'd1;
        end
      end
      OP_LOAD: prog_mem[{it.step_index, it.channel}] = it.value;
      OP_RENDER: levels_due.push_back(mixed_level(it.channel));
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin : monitor
    result_t want;
    if (rst) begin
      for (int c = 0; c < DEF_CHANNELS; c++) begin
        ovr_lvl[c] = '0;
        manual[c]  = 1'b0;
      end
      master     = FULL_LEVEL;
      saved      = '0;
      blk        = 1'b0;
      chase      = FULL_LEVEL;
      run        = 1'b1;
      step       = '0;
      wait_us    = RESET_WAIT;
      countdown  = '0;
      step_count = 7'd1;
      prog_width = '0;
      levels_due.delete();
    end else begin
      if (result_valid && result_ready) begin
        if (levels_due.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: result beat with no render pending: ch %0d level %0d",
                     $time, result.out_channel, result.level);
          mismatches++;
        end else begin
          want = levels_due.pop_front();
          if (result.out_channel !== want.out_channel || result.level !== want.level ||
              result.current_step !== want.current_step ||
              result.running !== want.running || result.blackout !== want.blackout) begin
            if (mismatches < 10)
              $display({"%0t: render mismatch: expected ch %0d level %0d step %0d ",
                        "run %0b blk %0b, got ch %0d level %0d step %0d run %0b blk %0b"},
                       $time, want.out_channel, want.level, want.current_step,
                       want.running, want.blackout, result.out_channel, result.level,
                       result.current_step, result.running, result.blackout);
            mismatches++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_STEP_COUNT) begin
          step_count = cfg_data[6:0];
          if (int'(step) >= steps_in_use()) step = '0;
        end else if (cfg_index == CFG_PROGRAM_WIDTH) begin
          prog_width = cfg_data;
        end
      end
      if (item_valid && item_ready) apply_beat(item);
    end
    awaiting    <= levels_due.size();
    step_now    <= step;
    fault_count <= mismatches;
  end

endmodule

### verif/tb.sv
`timescale 1ns / 1ps
// Testbench top for the program mixer: clock, reset, stimulus, watchdog and verdict.
// Depends on dpm_pkg, dmx_program_mixer and mixer_checker.
module tb;
  import dpm_pkg::*;

  localparam int         HOLD_CYCLES    = 48;
  localparam int         WATCHDOG_LIMIT = 5000;
  localparam int         PHASES         = 8;
  localparam int         PHASE_BEATS    = 125;
  localparam logic [3:0] OP_CODE_TOP    = 4'hF;

  logic                   clk;
  logic                   rst;
  logic                   item_valid;
  logic                   item_ready;
  item_t                  item;
  logic                   result_valid;
  logic                   result_ready;
  result_t                result;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  int                     fault_count;
  int                     awaiting;
  logic [5:0]             step_now;

  bit loaded [MAX_STEPS][DEF_CHANNELS];
  bit manual_ch [DEF_CHANNELS];
  int width_eff;
  bit calm;
  int beats_sent;
  int stall_left;
  int idle_cycles = 0;

  dmx_program_mixer i_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  mixer_checker i_checker (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .fault_count  (fault_count),
    .awaiting     (awaiting),
    .step_now     (step_now)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] pick_level();
    case ($urandom_range(0, 9))
      0: return 8'd0;
      1: return 8'd255;
      2: return BUTTON_THRESHOLD - 8'd1;
      3: return BUTTON_THRESHOLD;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [8:0] pick_channel();
    case ($urandom_range(0, 3))
      0, 1: return 9'($urandom_range(0, 15));
      2: return 9'($urandom_range(DEF_CHANNELS - 16, DEF_CHANNELS - 1));
      default: return 9'($urandom_range(0, DEF_CHANNELS - 1));
    endcase
  endfunction

  // enter and leave just after a falling edge; valid stays high for a back-to-back beat
  task automatic send(input logic [3:0] op, input logic [8:0] ch, input logic [7:0] val,
                      input logic [5:0] sidx);
    int    gap;
    item_t beat;
    gap = pick_gap();
    beat.operation  = op;
    beat.channel    = ch;
    beat.value      = val;
    beat.step_index = sidx;
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item       <= beat;
    item_valid <= 1'b1;
    do @(posedge clk); while (!item_ready);
    @(negedge clk);
    if (op == OP_OVERRIDE) manual_ch[ch] = 1'b1;
    if (op == OP_LOAD) loaded[sidx][ch] = 1'b1;
    if (op <= OP_RENDER) beats_sent++;
  endtask

  task automatic press(input logic [3:0] op, input logic [7:0] val);
    send(op, 9'($urandom_range(0, DEF_CHANNELS - 1)), val, 6'($urandom_range(0, 63)));
  endtask

  // load the byte first when the render would read an empty program slot
  task automatic render(input logic [8:0] ch);
    if (int'(ch) < width_eff && !manual_ch[ch] && !loaded[step_now][ch])
      send(OP_LOAD, ch, pick_level(), step_now);
    send(OP_RENDER, ch, pick_level(), 6'($urandom_range(0, 63)));
  endtask

  task automatic drain(input int hold);
    item_valid <= 1'b0;
    do @(posedge clk); while (awaiting != 0);
    repeat (hold) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_PROGRAM_WIDTH)
      width_eff = (int'(data) > DEF_CHANNELS) ? DEF_CHANNELS : int'(data);
    @(negedge clk);
  endtask

  initial begin : receiver
    result_ready = 1'b0;
    stall_left   = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        result_ready <= 1'b0;
        stall_left--;
      end else begin
        result_ready <= 1'b1;
        if (!calm && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int          r;
    int          target;
    int unsigned sc;
    int unsigned pw;
    bit          paused;
    rst        = 1'b1;
    item_valid = 1'b0;
    item       = '0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    calm       = 1'b0;
    width_eff  = 0;
    beats_sent = 0;
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    render(9'd0);
    send(OP_OVERRIDE, 9'd511, 8'd255, 6'd0);
    render(9'd511);
    drain(HOLD_CYCLES);
    write_reg(CFG_STEP_COUNT, 10'd4);
    write_reg(CFG_PROGRAM_WIDTH, 10'd16);
    send(OP_LOAD, 9'd1, 8'd255, 6'd0);
    render(9'd1);
    press(OP_CHASE, 8'd0);
    render(9'd1);
    press(OP_CHASE, 8'd128);
    press(OP_MASTER, 8'd200);
    press(OP_BLACKOUT, BUTTON_THRESHOLD);
    render(9'd1);
    press(OP_MASTER, 8'd17);
    press(OP_BLACKOUT, BUTTON_THRESHOLD - 8'd1);
    press(OP_BLACKOUT, 8'd255);
    render(9'd1);
    press(OP_BPM, 8'd255);
    press(OP_BPM, 8'd0);
    press(OP_RUN, BUTTON_THRESHOLD - 8'd1);
    press(OP_RUN, BUTTON_THRESHOLD);
    press(OP_RESTART, 8'd0);
    press(OP_TICK, 8'd0);
    press(OP_RUN, 8'd255);
    press(OP_TICK, 8'd255);
    render(9'd1);
    send(OP_OVERRIDE, 9'd0, 8'd0, 6'd63);
    render(9'd0);
    press(OP_CODE_TOP, 8'd255);
    send(OP_LOAD, 9'd511, 8'hA5, 6'd63);

    for (int ph = 1; ph < PHASES; ph++) begin
      case (ph)
        1: begin sc = 0;   pw = 512;  end
        2: begin sc = 64;  pw = 1023; end
        3: begin sc = 127; pw = 0;    end
        4: begin sc = 1;   pw = 600;  end
        5: begin sc = 65;  pw = 1;    end
        6: begin
          sc = $urandom_range(2, 63);
          pw = $urandom_range(2, 511);
        end
        default: begin sc = 3; pw = 511; end
      endcase
      drain(HOLD_CYCLES);
      write_reg(CFG_STEP_COUNT, 10'(sc));
      write_reg(CFG_PROGRAM_WIDTH, 10'(pw));
      calm   = (ph == 3) || ($urandom_range(0, 4) == 0);
      paused = 1'b0;
      target = beats_sent + PHASE_BEATS;
      while (beats_sent < target) begin
        if (!paused && beats_sent >= target - PHASE_BEATS / 2) begin
          drain(0);
          paused = 1'b1;
        end
        r = $urandom_range(0, 99);
        if (r < 36) begin
          render(pick_channel());
        end else if (r < 48) begin
          press(OP_TICK, pick_level());
        end else if (r < 55) begin
          press(OP_RESTART, pick_level());
        end else if (r < 60) begin
          press(OP_RESTART, pick_level());
          press(OP_TICK, pick_level());
          render(pick_channel());
        end else if (r < 64) begin
          send(OP_OVERRIDE, 9'($urandom_range(0, DEF_CHANNELS - 1)), pick_level(),
               6'($urandom_range(0, 63)));
        end else if (r < 68) begin
          press(OP_MASTER, pick_level());
        end else if (r < 72) begin
          press(OP_BLACKOUT, pick_level());
        end else if (r < 76) begin
          press(OP_CHASE, pick_level());
        end else if (r < 79) begin
          press(OP_BPM, pick_level());
        end else if (r < 84) begin
          press(OP_RUN, pick_level());
        end else if (r < 94) begin
          send(OP_LOAD, pick_channel(), pick_level(), 6'($urandom_range(0, 63)));
        end else begin
          press(4'(int'(OP_RENDER) + $urandom_range(1, int'(OP_CODE_TOP - OP_RENDER))),
                pick_level());
        end
      end
    end

    drain(HOLD_CYCLES);
    if (fault_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
